[rtl/core/csq_pkg.sv]
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the counting semaphore wait queue unit:
// command and status codes, datapath operations, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package csq_pkg;

    // Fixed field widths of the request and response beats
    localparam int CMD_W    = 3;
    localparam int TID_W    = 4;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 4;

    // Most results a single give_all produces
    localparam int RESULT_CAP = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TAKE      = 3'd0,
        CMD_TRY_TAKE  = 3'd1,
        CMD_GIVE      = 3'd2,
        CMD_GIVE_ALL  = 3'd3,
        CMD_CANCEL    = 3'd4,
        CMD_SET_COUNT = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 4'd0,
        ST_QUEUED   = 4'd1,
        ST_REFUSED  = 4'd2,
        ST_WOKE     = 4'd3,
        ST_RELEASED = 4'd4,
        ST_REMOVED  = 4'd5,
        ST_NOTWAIT  = 4'd6,
        ST_SET      = 4'd7,
        ST_ALREADY  = 4'd8
    } status_t;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,        // latch request beat
        OP_REPLY,       // result only, state unchanged
        OP_TAKE,        // count - 1, result
        OP_SET,         // load clamped count, result
        OP_ENQ_EMPTY,   // first waiter: self links, head, flag, count - 1, result
        OP_TAIL_RD,     // read prev link of head (the tail)
        OP_ENQ_LINK,    // link new waiter to head and tail
        OP_ENQ_DONE,    // close the ring, flag, count - 1, result
        OP_RELEASE,     // count + 1, result
        OP_WAKE_RD,     // target = head, read its links
        OP_CANCEL_RD,   // target = thread id, read its links
        OP_DEQ_DONE     // unlink target, flag clear, count + 1, result
    } dp_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ_LINK,
        S_ENQ_DONE,
        S_DEQ_DONE,
        S_GIVE_ALL
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic tid_ok;       // thread id below the thread count
        logic flag_tid;     // that thread is waiting
        logic empty;        // no thread waiting
        logic take_nonneg;  // count after a take stays >= 0
        logic count_pos;
        logic count_neg;
        logic ga_cap;       // give_all result cap reached
        logic out_free;     // output register can take a beat this cycle
    } dp_stat_t;

    // Operations that load the output register
    function automatic logic is_emit(dp_op_t op);
        logic r;
        case (op)
            OP_REPLY, OP_TAKE, OP_SET, OP_ENQ_EMPTY, OP_ENQ_DONE,
            OP_RELEASE, OP_DEQ_DONE: r = 1'b1;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/csq_req_if.sv]
// ----------------------------------------------------------------------------
// csq_req_if
// Request channel: valid/ready handshake with command, thread id and value.
// ----------------------------------------------------------------------------
interface csq_req_if;
    import csq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [TID_W-1:0]         thread_id;
    logic signed [VAL_W-1:0]  count_value;

    modport source (output valid, output command, output thread_id,
                    output count_value, input ready);
    modport sink   (input valid, input command, input thread_id,
                    input count_value, output ready);
endinterface

[rtl/core/csq_rsp_if.sv]
// ----------------------------------------------------------------------------
// csq_rsp_if
// Response channel: valid/ready handshake with one result beat.
// ----------------------------------------------------------------------------
interface csq_rsp_if;
    import csq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     woken_valid;
    logic [TID_W-1:0]         woken_thread;
    logic signed [VAL_W-1:0]  count_now;
    logic                     blocked;
    logic                     last;

    modport source (output valid, output status, output woken_valid,
                    output woken_thread, output count_now, output blocked,
                    output last, input ready);
    modport sink   (input valid, input status, input woken_valid,
                    input woken_thread, input count_now, input blocked,
                    input last, output ready);
endinterface

[rtl/core/csq_ram.sv]
// ----------------------------------------------------------------------------
// csq_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module csq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/core/csq_dp.sv]
// ----------------------------------------------------------------------------
// csq_dp
// Datapath: semaphore count with saturation, queue head, waiting flags,
// next/prev link RAMs of the circular wait ring, give_all result counter
// and the output register.
// ----------------------------------------------------------------------------
module csq_dp #(
    parameter int MAX_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csq_pkg::dp_cmd_t                  ctl,
    input  logic [csq_pkg::CMD_W-1:0]         command,
    input  logic [csq_pkg::TID_W-1:0]         thread_id,
    input  logic signed [csq_pkg::VAL_W-1:0]  count_value,
    output csq_pkg::dp_stat_t                 stat,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [csq_pkg::STATUS_W-1:0]      status,
    output logic                              woken_valid,
    output logic [csq_pkg::TID_W-1:0]         woken_thread,
    output logic signed [csq_pkg::VAL_W-1:0]  count_now,
    output logic                              blocked,
    output logic                              last
);
    import csq_pkg::*;

    localparam int     TW   = $clog2(MAX_THREADS);
    localparam int     CW   = COUNT_BITS;
    localparam int     SW   = (CW > VAL_W) ? CW + 1 : VAL_W + 1;
    localparam int     GW   = $clog2(RESULT_CAP + 1);
    localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN = -longint'(MAX_THREADS);

    // Latched request
    cmd_t                    cmd_reg;
    logic [TID_W-1:0]        tid_reg;
    logic signed [VAL_W-1:0] cv_reg;

    // Semaphore state
    logic signed [CW-1:0]    count_reg;
    logic [TW-1:0]           head_reg;
    logic [MAX_THREADS-1:0]  flags_reg;
    logic [TW-1:0]           target_reg;
    logic [GW-1:0]           ga_cnt_reg;

    // Output register
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic                    out_woken_reg;
    logic [TID_W-1:0]        out_thread_reg;
    logic signed [VAL_W-1:0] out_count_reg;
    logic                    out_blocked_reg;
    logic                    out_last_reg;

    // Link RAM ports
    logic                    rd_en;
    logic [TW-1:0]           rd_addr;
    logic                    nxt_we;
    logic [TW-1:0]           nxt_waddr;
    logic [TW-1:0]           nxt_wdata;
    logic [TW-1:0]           nxt_rdata;
    logic                    prv_we;
    logic [TW-1:0]           prv_waddr;
    logic [TW-1:0]           prv_wdata;
    logic [TW-1:0]           prv_rdata;

    logic [TW-1:0]           tid_idx;
    logic                    tid_ok;
    logic signed [CW:0]      cnt_w;
    logic signed [CW:0]      dec_w;
    logic signed [CW:0]      inc_w;
    logic signed [SW-1:0]    cv_w;
    logic signed [CW-1:0]    dec_c;
    logic signed [CW-1:0]    inc_c;
    logic signed [CW-1:0]    set_c;
    logic signed [CW-1:0]    count_next;
    logic                    emit;
    logic                    self_link;

    csq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    csq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    // Thread id decode
    assign tid_idx = TW'(tid_reg);
    assign tid_ok  = 32'(tid_reg) < 32'(MAX_THREADS);

    // Saturating count arithmetic
    assign cnt_w = (CW+1)'(count_reg);
    assign dec_w = cnt_w - (CW+1)'(1);
    assign inc_w = cnt_w + (CW+1)'(1);
    assign cv_w  = SW'(cv_reg);
    assign dec_c = (dec_w < (CW+1)'(CMIN)) ? CW'(CMIN) : dec_w[CW-1:0];
    assign inc_c = (inc_w > (CW+1)'(CMAX)) ? CW'(CMAX) : inc_w[CW-1:0];
    assign set_c = (cv_w > SW'(CMAX)) ? CW'(CMAX) :
                   (cv_w < SW'(CMIN)) ? CW'(CMIN) : cv_w[CW-1:0];

    always_comb
    begin
        case (ctl.op)
            OP_TAKE, OP_ENQ_EMPTY, OP_ENQ_DONE: count_next = dec_c;
            OP_RELEASE, OP_DEQ_DONE:            count_next = inc_c;
            OP_SET:                             count_next = set_c;
            default:                            count_next = count_reg;
        endcase
    end

    assign emit      = is_emit(ctl.op);
    assign self_link = (nxt_rdata == target_reg);

    // Status to the controller
    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.tid_ok      = tid_ok;
        stat.flag_tid    = tid_ok && flags_reg[tid_idx];
        stat.empty       = ~|flags_reg;
        stat.take_nonneg = !dec_c[CW-1];
        stat.count_pos   = !count_reg[CW-1] && (|count_reg);
        stat.count_neg   = count_reg[CW-1];
        stat.ga_cap      = (ga_cnt_reg == GW'(RESULT_CAP));
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

    // Link RAM access per operation
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = head_reg;
        nxt_we    = 1'b0;
        nxt_waddr = tid_idx;
        nxt_wdata = tid_idx;
        prv_we    = 1'b0;
        prv_waddr = tid_idx;
        prv_wdata = tid_idx;
        case (ctl.op)
            OP_ENQ_EMPTY:
            begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
            end
            OP_TAIL_RD, OP_WAKE_RD:
            begin
                rd_en = 1'b1;
            end
            OP_CANCEL_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = tid_idx;
            end
            OP_ENQ_LINK:
            begin
                // new waiter points at head and at the old tail
                nxt_we    = 1'b1;
                nxt_wdata = head_reg;
                prv_we    = 1'b1;
                prv_wdata = prv_rdata;
            end
            OP_ENQ_DONE:
            begin
                // old tail and head point at the new waiter
                nxt_we    = 1'b1;
                nxt_waddr = prv_rdata;
                prv_we    = 1'b1;
                prv_waddr = head_reg;
            end
            OP_DEQ_DONE:
            begin
                nxt_we    = !self_link;
                nxt_waddr = prv_rdata;
                nxt_wdata = nxt_rdata;
                prv_we    = !self_link;
                prv_waddr = nxt_rdata;
                prv_wdata = prv_rdata;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Request latch and dequeue target
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD)
        begin
            cmd_reg <= cmd_t'(command);
            tid_reg <= thread_id;
            cv_reg  <= count_value;
        end
        if (ctl.op == OP_WAKE_RD)
        begin
            target_reg <= head_reg;
        end
        else if (ctl.op == OP_CANCEL_RD)
        begin
            target_reg <= tid_idx;
        end
    end

    // Semaphore state and give_all counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= CW'(1);
            head_reg   <= '0;
            flags_reg  <= '0;
            ga_cnt_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                count_reg <= count_next;
            end
            case (ctl.op)
                OP_LOAD:
                begin
                    ga_cnt_reg <= '0;
                end
                OP_ENQ_EMPTY:
                begin
                    head_reg           <= tid_idx;
                    flags_reg[tid_idx] <= 1'b1;
                end
                OP_ENQ_DONE:
                begin
                    flags_reg[tid_idx] <= 1'b1;
                end
                OP_RELEASE:
                begin
                    ga_cnt_reg <= ga_cnt_reg + GW'(1);
                end
                OP_DEQ_DONE:
                begin
                    ga_cnt_reg            <= ga_cnt_reg + GW'(1);
                    flags_reg[target_reg] <= 1'b0;
                    if (self_link)
                    begin
                        head_reg <= '0;
                    end
                    else if (head_reg == target_reg)
                    begin
                        head_reg <= nxt_rdata;
                    end
                end
                default:
                begin
                    ga_cnt_reg <= ga_cnt_reg;
                end
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg  <= ctl.status;
            out_woken_reg   <= (ctl.status == ST_WOKE);
            out_thread_reg  <= (ctl.status == ST_WOKE) ? TID_W'(target_reg) : '0;
            out_count_reg   <= VAL_W'(count_next);
            out_blocked_reg <= count_next[CW-1];
            out_last_reg    <= (cmd_reg != CMD_GIVE_ALL) || !count_next[CW-1] ||
                               (ga_cnt_reg == GW'(RESULT_CAP - 1));
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign woken_valid  = out_woken_reg;
    assign woken_thread = out_thread_reg;
    assign count_now    = out_count_reg;
    assign blocked      = out_blocked_reg;
    assign last         = out_last_reg;
endmodule

[rtl/core/csq_ctrl.sv]
// ----------------------------------------------------------------------------
// csq_ctrl
// Controller: decodes the latched command and sequences datapath operations
// (link reads and writes, result beats, the give_all walk). Result beats are
// held back while the output register is full.
// ----------------------------------------------------------------------------
module csq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  csq_pkg::dp_stat_t  stat,
    output csq_pkg::dp_cmd_t   ctl
);
    import csq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    dp_cmd_t     ctl_pre;
    ctrl_state_t state_pre;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and operation
    always_comb
    begin
        req_ready      = 1'b0;
        ctl_pre.op     = OP_NONE;
        ctl_pre.status = ST_GRANTED;
        state_pre      = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl_pre.op = OP_LOAD;
                    state_pre  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_pre = S_IDLE;
                case (stat.cmd)
                    CMD_TAKE:
                    begin
                        if (!stat.tid_ok)
                        begin
                            ctl_pre.op     = OP_REPLY;
                            ctl_pre.status = ST_REFUSED;
                        end
                        else if (stat.flag_tid)
                        begin
                            ctl_pre.op     = OP_REPLY;
                            ctl_pre.status = ST_ALREADY;
                        end
                        else if (stat.take_nonneg)
                        begin
                            ctl_pre.op     = OP_TAKE;
                            ctl_pre.status = ST_GRANTED;
                        end
                        else if (stat.empty)
                        begin
                            ctl_pre.op     = OP_ENQ_EMPTY;
                            ctl_pre.status = ST_QUEUED;
                        end
                        else
                        begin
                            ctl_pre.op = OP_TAIL_RD;
                            state_pre  = S_ENQ_LINK;
                        end
                    end
                    CMD_TRY_TAKE:
                    begin
                        ctl_pre.op     = stat.count_pos ? OP_TAKE : OP_REPLY;
                        ctl_pre.status = stat.count_pos ? ST_GRANTED : ST_REFUSED;
                    end
                    CMD_GIVE:
                    begin
                        if (stat.empty)
                        begin
                            ctl_pre.op     = OP_RELEASE;
                            ctl_pre.status = ST_RELEASED;
                        end
                        else
                        begin
                            ctl_pre.op = OP_WAKE_RD;
                            state_pre  = S_DEQ_DONE;
                        end
                    end
                    CMD_GIVE_ALL:
                    begin
                        state_pre = S_GIVE_ALL;
                    end
                    CMD_CANCEL:
                    begin
                        if (stat.flag_tid)
                        begin
                            ctl_pre.op = OP_CANCEL_RD;
                            state_pre  = S_DEQ_DONE;
                        end
                        else
                        begin
                            ctl_pre.op     = OP_REPLY;
                            ctl_pre.status = ST_NOTWAIT;
                        end
                    end
                    CMD_SET_COUNT:
                    begin
                        ctl_pre.op     = OP_SET;
                        ctl_pre.status = ST_SET;
                    end
                    default:
                    begin
                        ctl_pre.op     = OP_REPLY;
                        ctl_pre.status = ST_REFUSED;
                    end
                endcase
            end
            S_ENQ_LINK:
            begin
                ctl_pre.op = OP_ENQ_LINK;
                state_pre  = S_ENQ_DONE;
            end
            S_ENQ_DONE:
            begin
                ctl_pre.op     = OP_ENQ_DONE;
                ctl_pre.status = ST_QUEUED;
                state_pre      = S_IDLE;
            end
            S_DEQ_DONE:
            begin
                ctl_pre.op     = OP_DEQ_DONE;
                ctl_pre.status = (stat.cmd == CMD_CANCEL) ? ST_REMOVED : ST_WOKE;
                state_pre      = (stat.cmd == CMD_GIVE_ALL) ? S_GIVE_ALL : S_IDLE;
            end
            S_GIVE_ALL:
            begin
                // one wake or release per step while the count is negative and the cap is not reached
                if (!stat.count_neg || stat.ga_cap)
                begin
                    state_pre = S_IDLE;
                end
                else if (stat.empty)
                begin
                    ctl_pre.op     = OP_RELEASE;
                    ctl_pre.status = ST_RELEASED;
                end
                else
                begin
                    ctl_pre.op = OP_WAKE_RD;
                    state_pre  = S_DEQ_DONE;
                end
            end
            default:
            begin
                state_pre = S_IDLE;
            end
        endcase

        // hold a result beat until the output register is free
        if (is_emit(ctl_pre.op) && !stat.out_free)
        begin
            ctl        = '{op: OP_NONE, status: ST_GRANTED};
            state_next = state_reg;
        end
        else
        begin
            ctl        = ctl_pre;
            state_next = state_pre;
        end
    end
endmodule

[rtl/core/counting_semaphore_wait_queue_unit.sv]
// Steps after decode: grant, refuse, set, release answer directly; wake, cancel
// read links then unlink; a take into a busy queue reads tail, links, closes ring.
// Throughput: one request at a time, a new beat accepted in the idle state only;
// give_all wakes one waiter at a time (link RAM read, then unlink).
// Reset: count = 1, queue empty, waiting flags cleared; link RAMs not cleared.
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a FIFO wait queue of thread numbers, kept as a
// circular doubly linked ring in two link RAMs. Controller and datapath.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit #(
    parameter int MAX_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    csq_req_if.sink    req,
    csq_rsp_if.source  rsp
);
    import csq_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    csq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    csq_dp #(
        .MAX_THREADS (MAX_THREADS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .command      (req.command),
        .thread_id    (req.thread_id),
        .count_value  (req.count_value),
        .stat         (stat),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .status       (rsp.status),
        .woken_valid  (rsp.woken_valid),
        .woken_thread (rsp.woken_thread),
        .count_now    (rsp.count_now),
        .blocked      (rsp.blocked),
        .last         (rsp.last)
    );

`ifndef NO_ASSERTIONS
    // a request beat is taken only from idle, so never twice in a row
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while previous request in progress");

    // result beats are only issued into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        is_emit(ctl.op) |-> (!rsp.valid || rsp.ready))
        else $error("result beat overwrote a pending beat");

    // woken thread is flagged exactly on wake results
    a_woken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.woken_valid == (rsp.status == ST_WOKE)))
        else $error("woken_valid does not match status");
`endif
endmodule
